@@ src/i2a_pkg.sv @@
package i2a_pkg;

	// Operand and digit geometry.
	localparam int VAL_W      = 64;
	localparam int CNT_W      = 6;
	localparam int MAX_DIGITS = 20;
	localparam int DIG_W      = 4;
	localparam int REM_W      = $clog2(MAX_DIGITS + 1);
	localparam int HEX_DIGITS = VAL_W / DIG_W;

	// Command codes.
	localparam logic [2:0] CMD_CHAR   = 3'd0;
	localparam logic [2:0] CMD_DEC32  = 3'd1;
	localparam logic [2:0] CMD_DEC64  = 3'd2;
	localparam logic [2:0] CMD_HEX_LO = 3'd3;
	localparam logic [2:0] CMD_HEX_UP = 3'd4;

	// Characters.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_A_UP  = 8'h41;

	// Per-cycle control for the digit row.
	typedef struct packed {
		logic load;
		logic dabble;
		logic move;
	} cell_ctl_t;

	// ASCII for one digit, lowercase or uppercase letters above nine.
	function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
		logic [7:0] base;
		begin
			if (d < DIG_W'(10)) begin
				digit_char = CH_ZERO + 8'(d);
			end else begin
				base = upper ? CH_A_UP : CH_A_LO;
				digit_char = base + 8'(d - DIG_W'(10));
			end
		end
	endfunction

endpackage

@@ src/i2a_cell.sv @@
module i2a_cell (
	input  logic                       clk,
	input  i2a_pkg::cell_ctl_t         ctl,
	input  logic [i2a_pkg::DIG_W-1:0]  ld_digit,
	input  logic [i2a_pkg::DIG_W-1:0]  lower_digit,
	input  logic                       cin,
	output logic                       cout,
	output logic [i2a_pkg::DIG_W-1:0]  digit
);
	import i2a_pkg::*;

	logic [DIG_W-1:0] digit_q;
	logic [DIG_W-1:0] adj;

	// Add three to a digit of five or more before the doubling step.
	always_comb begin
		adj = (digit_q >= DIG_W'(5)) ? digit_q + DIG_W'(3) : digit_q;
	end

	assign cout  = adj[DIG_W-1];
	assign digit = digit_q;

	// Load, double with carry in from the lower cell, or take the lower cell's digit.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			digit_q <= ld_digit;
		end else if (ctl.dabble) begin
			digit_q <= {adj[DIG_W-2:0], cin};
		end else if (ctl.move) begin
			digit_q <= lower_digit;
		end
	end

endmodule

@@ src/int_to_ascii_dec_hex_top.sv @@
// Channel  Handshake        Ports
// input    start / busy     cmd, value
// output   strobe (no stall) out_char, last
//
// A character command gives its word in the cycle after start; busy stays low.
// Decimal commands load the row, run one double-dabble step per operand bit through
// the digit row, show a '-' when negative, then walk all 20 cells of the row.
// Hex commands load the row directly and then walk all 20 cells of it.
// Leading zero digits are walked past without a strobe; each word is one cycle.
// Reset clears the control state; the receiver takes every word as shown.
module int_to_ascii_dec_hex_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 cmd,
	input  logic [i2a_pkg::VAL_W-1:0]  value,
	output logic [7:0]                 out_char,
	output logic                       last,
	output logic                       strobe
);
	import i2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [VAL_W-1:0] bin_q;
	logic             neg_q;
	logic             upper_q;
	logic             started_q;
	logic [7:0]       out_char_q;
	logic             last_q;
	logic             strobe_q;

	logic             accept;
	cell_ctl_t        ctl;
	logic [DIG_W-1:0] ld_digit [MAX_DIGITS];
	logic [DIG_W-1:0] digit    [MAX_DIGITS];
	logic [DIG_W-1:0] lower    [MAX_DIGITS];
	logic             carry    [MAX_DIGITS+1];
	logic [DIG_W-1:0] top_digit;
	logic             skip;
	logic [31:0]      mag32;
	logic [VAL_W-1:0] mag64;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign out_char = out_char_q;
	assign last     = last_q;
	assign strobe   = strobe_q;

	assign mag32     = value[31] ? 32'd0 - value[31:0] : value[31:0];
	assign mag64     = value[VAL_W-1] ? {VAL_W{1'b0}} - value : value;
	assign top_digit = digit[MAX_DIGITS-1];
	assign skip      = !started_q && (top_digit == '0) && (rem_q != REM_W'(1));

	// Row control: load on a decimal or hex start, dabble while converting, walk while emitting.
	always_comb begin
		ctl.load   = accept && (cmd == CMD_DEC32 || cmd == CMD_DEC64 ||
		                        cmd == CMD_HEX_LO || cmd == CMD_HEX_UP);
		ctl.dabble = (state_q == ST_CONV);
		ctl.move   = (state_q == ST_EMIT);
	end

	// Hex loads nibbles into the low cells; decimal clears the row.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (i < HEX_DIGITS && (cmd == CMD_HEX_LO || cmd == CMD_HEX_UP)) begin
				ld_digit[i] = value[i*DIG_W +: DIG_W];
			end else begin
				ld_digit[i] = '0;
			end
		end
	end

	// Neighbor links: carries run up during conversion, digits run up during emission.
	assign carry[0] = bin_q[VAL_W-1];
	assign lower[0] = '0;
	genvar g;
	generate
		for (g = 1; g < MAX_DIGITS; g++) begin : g_link
			assign lower[g] = digit[g-1];
		end
		for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
			i2a_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.ld_digit    (ld_digit[g]),
				.lower_digit (lower[g]),
				.cin         (carry[g]),
				.cout        (carry[g+1]),
				.digit       (digit[g])
			);
		end
	endgenerate

	// Operand shift register feeding the bottom cell.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_DEC32) begin
			bin_q <= {{(VAL_W-32){1'b0}}, mag32};
		end else if (accept && cmd == CMD_DEC64) begin
			bin_q <= mag64;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	// Sequencer and output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rem_q      <= '0;
			neg_q      <= 1'b0;
			upper_q    <= 1'b0;
			started_q  <= 1'b0;
			out_char_q <= '0;
			last_q     <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q     <= '0;
						rem_q     <= REM_W'(MAX_DIGITS);
						started_q <= 1'b0;
						upper_q   <= (cmd == CMD_HEX_UP);
						case (cmd)
							CMD_CHAR: begin
								out_char_q <= value[7:0];
								last_q     <= 1'b1;
								strobe_q   <= 1'b1;
							end
							CMD_DEC32: begin
								neg_q   <= value[31];
								state_q <= ST_CONV;
							end
							CMD_DEC64: begin
								neg_q   <= value[VAL_W-1];
								state_q <= ST_CONV;
							end
							CMD_HEX_LO, CMD_HEX_UP: begin
								neg_q   <= 1'b0;
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == {CNT_W{1'b1}}) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					out_char_q <= CH_MINUS;
					last_q     <= 1'b0;
					strobe_q   <= 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					rem_q <= rem_q - REM_W'(1);
					if (!skip) begin
						started_q  <= 1'b1;
						out_char_q <= digit_char(top_digit, upper_q);
						last_q     <= (rem_q == REM_W'(1));
						strobe_q   <= 1'b1;
					end
					if (rem_q == REM_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The final word of an item always leaves the block ready for the next one.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("last word shown while still busy");

	// Conversion ends after a full pass over the operand bits.
	a_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cnt_q == {CNT_W{1'b1}}) |=>
		(state_q == ST_SIGN || state_q == ST_EMIT))
		else $error("conversion did not hand over to emission");

	// The digit walk count stays within the row.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q != '0 && rem_q <= REM_W'(MAX_DIGITS)))
		else $error("digit walk count out of range");

	// Once a digit has been shown, no later digit of the item is skipped.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && started_q) |=> strobe)
		else $error("digit dropped after the first shown digit");
`endif

endmodule

@@ tb/tb.sv @@
module tb;
	import i2a_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Command codes that the block ignores.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam logic [7:0] ASCII_DASH = 8'h2d;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	localparam int RANDOM_WORDS   = 88;
	localparam int MAX_GAP        = 9;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 1000;

	// One conversion request and the idle time the driver leaves after it.
	typedef struct {
		logic [2:0]  op;
		logic [63:0] operand;
		int unsigned gap_after;
	} conv_word_t;

	// One character the block should emit.
	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} ascii_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [2:0]        cmd = 3'd0;
	logic [VAL_W-1:0]  value = '0;
	logic              busy;
	logic [7:0]        out_char;
	logic              last;
	logic              strobe;

	conv_word_t  pending_words[$];
	ascii_char_t expected_chars[$];
	int unsigned idle_left = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;

	int_to_ascii_dec_hex_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.value    (value),
		.out_char (out_char),
		.last     (last),
		.strobe   (strobe)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Work out the characters a request produces and queue them in order.
	function automatic void predict_chars(input logic [2:0] op, input logic [63:0] operand);
		string       lo_tab;
		string       up_tab;
		logic [63:0] mag;
		logic [31:0] mag32;
		logic [7:0]  rev[$];
		logic [3:0]  nib;
		logic        neg;
		logic        hex;
		logic        upper;
		int          i;
		lo_tab = "0123456789abcdef";
		up_tab = "0123456789ABCDEF";
		neg = 1'b0;
		hex = 1'b0;
		upper = 1'b0;
		mag = '0;
		case (op)
			CMD_CHAR: begin
				expected_chars.push_back('{operand[7:0], 1'b1});
				return;
			end
			CMD_DEC32: begin
				neg = operand[31];
				mag32 = neg ? 32'd0 - operand[31:0] : operand[31:0];
				mag = {32'd0, mag32};
			end
			CMD_DEC64: begin
				neg = operand[63];
				mag = neg ? 64'd0 - operand : operand;
			end
			CMD_HEX_LO: begin
				hex = 1'b1;
				mag = operand;
			end
			CMD_HEX_UP: begin
				hex = 1'b1;
				upper = 1'b1;
				mag = operand;
			end
			default: begin
				return;
			end
		endcase
		if (neg) begin
			expected_chars.push_back('{ASCII_DASH, 1'b0});
		end
		// Digits come out least significant first, capped at the digit limit.
		while (mag != 0 && rev.size() < MAX_DIGITS) begin
			if (hex) begin
				nib = mag[3:0];
				rev.push_back(upper ? up_tab[nib] : lo_tab[nib]);
				mag = mag >> 4;
			end else begin
				rev.push_back(ASCII_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end
		end
		if (rev.size() == 0) begin
			rev.push_back(ASCII_ZERO);
		end
		for (i = rev.size() - 1; i >= 0; i--) begin
			expected_chars.push_back('{rev[i], i == 0});
		end
	endfunction

	// Random operand with a random significant width, so every digit count shows up.
	function automatic logic [63:0] pick_operand();
		logic [63:0]  raw;
		int unsigned  span;
		raw = {$urandom, $urandom};
		span = $urandom_range(1, 64);
		if (span < 64) begin
			raw = raw & ((64'd1 << span) - 64'd1);
		end
		case ($urandom_range(0, 3))
			0: raw = ~raw;
			1: raw[63:32] = $urandom;
			default: ;
		endcase
		return raw;
	endfunction

	task automatic queue_word(input logic [2:0] op, input logic [63:0] operand,
			input int unsigned gap);
		pending_words.push_back('{op, operand, gap});
	endtask

	// Driver: present the next word, hold it while busy, and predict on acceptance.
	always @(posedge clk) begin
		conv_word_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_chars(cmd, value);
			end
			if (start && busy) begin
				// Keep the word on the ports until the block takes it.
			end else if (idle_left != 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
				cmd <= 3'($urandom);
				value <= {$urandom, $urandom};
			end else if (pending_words.size() != 0) begin
				nxt = pending_words.pop_front();
				start <= 1'b1;
				cmd <= nxt.op;
				value <= nxt.operand;
				idle_left <= nxt.gap_after;
			end else begin
				start <= 1'b0;
				cmd <= 3'($urandom);
				value <= {$urandom, $urandom};
			end
		end
	end

	// Monitor: every strobed character must match the oldest expected one.
	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b", out_char, last));
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch || last !== want.fin) begin
					report_mismatch($sformatf("char %h last %b, expected char %h last %b",
						out_char, last, want.ch, want.fin));
				end
			end
		end
	end

	// Watchdog: too long without an accepted word or a strobed character.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: watchdog expired after %0d idle cycles", stall_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned made;
		int unsigned gap;
		logic        calm;
		logic [2:0]  op;

		// Directed corners: byte extremes, signed extremes, hex patterns, unused codes.
		queue_word(CMD_CHAR,   64'h0, $urandom_range(0, MAX_GAP));
		queue_word(CMD_CHAR,   64'hff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_CHAR,   64'hffff_ffff_ffff_ff41, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC32,  64'h0, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC32,  64'h1, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC32,  64'h1234_5678_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC32,  64'hffff_ffff_8000_0000, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC32,  64'h8000_0000_7fff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC64,  64'h0, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC64,  64'h1, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC64,  64'hffff_ffff_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC64,  64'h8000_0000_0000_0000, $urandom_range(0, MAX_GAP));
		queue_word(CMD_DEC64,  64'h7fff_ffff_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_LO, 64'h0, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_LO, 64'hffff_ffff_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_LO, 64'h0123_4567_89ab_cdef, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_UP, 64'h1, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_UP, 64'hffff_ffff_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_HEX_UP, 64'hfedc_ba98_7654_3210, $urandom_range(0, MAX_GAP));
		queue_word(CMD_SPARE_LO, 64'h1, $urandom_range(0, MAX_GAP));
		queue_word(3'(CMD_SPARE_LO + 1), 64'hffff_ffff_ffff_ffff, $urandom_range(0, MAX_GAP));
		queue_word(CMD_SPARE_HI, 64'h8000_0000_0000_0000, 0);
		queue_word(CMD_DEC64,  64'h8ac7_2304_89e7_ffff, 0);

		// Random words; every third stretch of sixteen runs back to back.
		made = 0;
		while (made < RANDOM_WORDS) begin
			calm = ((made / 16) % 3) == 1;
			gap = calm ? 0 : $urandom_range(0, MAX_GAP);
			case ($urandom_range(0, 9))
				0: op = CMD_CHAR;
				1, 2: op = CMD_DEC32;
				3, 4: op = CMD_DEC64;
				5, 6: op = CMD_HEX_LO;
				7, 8: op = CMD_HEX_UP;
				default: op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			endcase
			queue_word(op, pick_operand(), gap);
			if (op < CMD_SPARE_LO) begin
				made++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all words to be taken and all characters to come back.
		while (pending_words.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/i2a_pkg.sv
src/i2a_cell.sv
src/int_to_ascii_dec_hex_top.sv
tb/tb.sv
